### src/hsj_pkg.sv
// ----------------------------------------------------------------------------
// hsj_pkg
// Shared types, constants and helpers of the seven-point heat stencil block.
// ----------------------------------------------------------------------------
package hsj_pkg;

	localparam int SIZE_W    = 7;
	localparam int COEF_W    = 18;
	localparam int DATA_W    = 32;
	localparam int RES_W     = 64;
	localparam int CNT_W     = 8;
	localparam int DIST_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = DATA_W + COEF_W;
	localparam int ACC_W     = PROD_W + 4;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Z = 3'd6;

	localparam logic [SIZE_W-1:0] SIZE_RESET   = 7'd16;
	localparam logic [COEF_W-1:0] CENTER_RESET = 18'd16384;
	localparam logic [COEF_W-1:0] WEIGHT_RESET = 18'd8192;

	// One queued item: the sample and what the front decided about it.
	typedef struct packed {
		logic [DATA_W-1:0] sample;
		logic              first;
		logic              emit;
		logic              last;
		logic [CNT_W-1:0]  row_len;
		logic [DIST_W-1:0] plane_len;
	} job_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] center;
		logic signed [COEF_W-1:0] wx;
		logic signed [COEF_W-1:0] wy;
		logic signed [COEF_W-1:0] wz;
	} coef_t;

	// Zero acts as one, and a size above the maximum acts as the maximum.
	function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int maxv);
		logic [CNT_W-1:0] s;
		s = CNT_W'(v);
		if (s == '0) s = CNT_W'(1);
		if (int'(s) > maxv) s = CNT_W'(maxv);
		return s;
	endfunction

endpackage

### src/hsj_if.sv
// ----------------------------------------------------------------------------
// hsj_if
// Valid/ready channels of the heat stencil block: samples in, results out.
// ----------------------------------------------------------------------------
interface hsj_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [hsj_pkg::DATA_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface hsj_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [hsj_pkg::DATA_W-1:0] new_value;
	logic [hsj_pkg::RES_W-1:0]         residual_sum;
	logic                              last_point;

	modport source (output valid, output new_value, output residual_sum, output last_point,
		input ready);
	modport sink   (input valid, input new_value, input residual_sum, input last_point,
		output ready);
endinterface

### src/heat_stencil_jacobi_step.sv
// ----------------------------------------------------------------------------
// heat_stencil_jacobi_step
// One explicit seven-point heat-equation step streamed over a 3D block.
// ----------------------------------------------------------------------------
// Samples (signed Q16.16) arrive on sample_ch in raster order, x fastest,
// covering the block and its one-point halo. For every interior point one
// item leaves on result_ch with the new temperature, the saturating running
// sum of squared changes and a mark on the final interior point.
// The front counts the raster position and classifies each item; a two-entry
// queue decouples it from the back, which writes the sample into the window
// ring and evaluates the stencil with one shared multiplier.
// A halo sample is only written into the window memory. An interior point also
// makes six reads (the centre and five neighbours) through the single read port
// of the window memory, seven multiplications through the shared multiplier,
// then rounding, squaring and the residual update.
// The result register holds an item while the receiver stalls; the back stops
// at its last step and the queue then fills, after which sample_ch.ready drops.
// Reset clears the counters, pointers and residual and loads the register
// defaults. The window memory needs no clearing: every read hits an entry
// written earlier in the same block. Writing a size register restarts the block.
// ----------------------------------------------------------------------------
module heat_stencil_jacobi_step #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hsj_sample_if.sink                     sample_ch,
	hsj_result_if.source                   result_ch,
	input  logic                           cfg_we,
	input  logic [hsj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsj_pkg::COEF_W-1:0]     cfg_data
);

	logic [hsj_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	hsj_pkg::coef_t             coef_q;
	logic                       restart;
	logic                       q_full, push, pop, head_valid;
	hsj_pkg::job_t              push_job, head;

	// Any write to a size register returns the raster counters to the start.
	assign restart = cfg_we && ((cfg_index == hsj_pkg::REG_SIZE_X)
		|| (cfg_index == hsj_pkg::REG_SIZE_Y) || (cfg_index == hsj_pkg::REG_SIZE_Z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q      <= hsj_pkg::SIZE_RESET;
			size_y_q      <= hsj_pkg::SIZE_RESET;
			size_z_q      <= hsj_pkg::SIZE_RESET;
			coef_q.center <= hsj_pkg::CENTER_RESET;
			coef_q.wx     <= hsj_pkg::WEIGHT_RESET;
			coef_q.wy     <= hsj_pkg::WEIGHT_RESET;
			coef_q.wz     <= hsj_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsj_pkg::REG_SIZE_X:   size_x_q      <= cfg_data[hsj_pkg::SIZE_W-1:0];
				hsj_pkg::REG_SIZE_Y:   size_y_q      <= cfg_data[hsj_pkg::SIZE_W-1:0];
				hsj_pkg::REG_SIZE_Z:   size_z_q      <= cfg_data[hsj_pkg::SIZE_W-1:0];
				hsj_pkg::REG_CENTER:   coef_q.center <= cfg_data;
				hsj_pkg::REG_WEIGHT_X: coef_q.wx     <= cfg_data;
				hsj_pkg::REG_WEIGHT_Y: coef_q.wy     <= cfg_data;
				hsj_pkg::REG_WEIGHT_Z: coef_q.wz     <= cfg_data;
				default: ;
			endcase
		end
	end

	hsj_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.size_x    (size_x_q),
		.size_y    (size_y_q),
		.size_z    (size_z_q),
		.restart   (restart),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	hsj_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hsj_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.coef       (coef_q),
		.result_ch  (result_ch)
	);

endmodule

### src/hsj_ram.sv
// ----------------------------------------------------------------------------
// hsj_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hsj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### src/hsj_queue.sv
// ----------------------------------------------------------------------------
// hsj_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hsj_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hsj_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output hsj_pkg::job_t head
);

	hsj_pkg::job_t entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### src/hsj_front.sv
// ----------------------------------------------------------------------------
// hsj_front
// Accepts samples, tracks the raster position and classifies each item.
// ----------------------------------------------------------------------------
module hsj_front #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hsj_sample_if.sink                  sample_ch,
	input  logic [hsj_pkg::SIZE_W-1:0]  size_x,
	input  logic [hsj_pkg::SIZE_W-1:0]  size_y,
	input  logic [hsj_pkg::SIZE_W-1:0]  size_z,
	input  logic                        restart,
	input  logic                        q_full,
	output logic                        push,
	output hsj_pkg::job_t               push_job
);

	logic [hsj_pkg::CNT_W-1:0] sx, sy, sz;
	logic [hsj_pkg::CNT_W-1:0] col_q, row_q, plane_q;
	logic [hsj_pkg::CNT_W-1:0] row_len, col_h;
	logic                      col_end, row_end, plane_end;

	assign sx      = hsj_pkg::eff_size(size_x, MAX_X);
	assign sy      = hsj_pkg::eff_size(size_y, MAX_Y);
	assign sz      = hsj_pkg::eff_size(size_z, MAX_Z);
	assign row_len = sx + hsj_pkg::CNT_W'(2);
	assign col_h   = sy + hsj_pkg::CNT_W'(2);

	assign sample_ch.ready = !q_full;
	assign push            = sample_ch.valid && !q_full;

	assign col_end   = (col_q == sx + hsj_pkg::CNT_W'(1));
	assign row_end   = (row_q == sy + hsj_pkg::CNT_W'(1));
	assign plane_end = (plane_q == sz + hsj_pkg::CNT_W'(1));

	always_comb begin
		push_job.sample    = sample_ch.sample;
		push_job.first     = (col_q == '0) && (row_q == '0) && (plane_q == '0);
		push_job.emit      = (col_q >= hsj_pkg::CNT_W'(1)) && (col_q <= sx)
			&& (row_q >= hsj_pkg::CNT_W'(1)) && (row_q <= sy)
			&& (plane_q >= hsj_pkg::CNT_W'(2)) && (plane_q <= sz + hsj_pkg::CNT_W'(1));
		push_job.last      = (col_q == sx) && (row_q == sy) && plane_end;
		push_job.row_len   = row_len;
		push_job.plane_len = hsj_pkg::DIST_W'(row_len) * hsj_pkg::DIST_W'(col_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (push) begin
			if (!col_end) begin
				col_q <= col_q + hsj_pkg::CNT_W'(1);
			end else begin
				col_q <= '0;
				if (!row_end) begin
					row_q <= row_q + hsj_pkg::CNT_W'(1);
				end else begin
					row_q   <= '0;
					plane_q <= plane_end ? '0 : plane_q + hsj_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

### src/hsj_back.sv
// ----------------------------------------------------------------------------
// hsj_back
// Stores samples in the window ring and evaluates the stencil for each item.
// ----------------------------------------------------------------------------
module hsj_back #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  hsj_pkg::job_t head,
	output logic          pop,
	input  hsj_pkg::coef_t coef,
	hsj_result_if.source  result_ch
);

	localparam int DEPTH = 2 * (MAX_X + 2) * (MAX_Y + 2) + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = (AW + 1 > hsj_pkg::DIST_W) ? AW + 1 : hsj_pkg::DIST_W;

	localparam logic [3:0] ST_SAMPLE    = 4'd7;
	localparam logic [3:0] ST_ROUND     = 4'd9;
	localparam logic [3:0] ST_SQUARE    = 4'd10;
	localparam logic [3:0] ST_OUT       = 4'd11;

	localparam logic signed [hsj_pkg::ACC_W-17:0] NV_MAX =
		{{(hsj_pkg::ACC_W-48){1'b0}}, 32'h7fffffff};
	localparam logic signed [hsj_pkg::ACC_W-17:0] NV_MIN =
		{{(hsj_pkg::ACC_W-48){1'b1}}, 32'h80000000};

	hsj_pkg::job_t job_q;
	logic          busy_q;
	logic [3:0]    st_q;
	logic [AW-1:0] wr_q, base_q, raddr;
	logic [hsj_pkg::DATA_W-1:0] rdata;

	logic [hsj_pkg::DIST_W-1:0] nb_dist;
	logic [SUM_W-1:0]           sum;

	logic signed [hsj_pkg::DATA_W-1:0]  mul_a;
	logic signed [hsj_pkg::COEF_W-1:0]  mul_b;
	logic signed [hsj_pkg::PROD_W-1:0]  prod_s1;
	logic                               prod_v_s1;
	logic signed [hsj_pkg::ACC_W-1:0]   acc_q;
	logic signed [hsj_pkg::ACC_W-1:0]   rnd;
	logic signed [hsj_pkg::ACC_W-17:0]  nv_full;
	logic signed [hsj_pkg::DATA_W-1:0]  c_q, nv_q;
	logic signed [hsj_pkg::DATA_W:0]    diff;
	logic [hsj_pkg::DATA_W:0]           mag;
	logic [hsj_pkg::RES_W-1:0]          sq_q, res_q;
	logic [hsj_pkg::RES_W:0]            res_sum;
	logic                               out_valid_q, load_out;

	assign pop = head_valid && !busy_q;

	hsj_ram #(.WIDTH(hsj_pkg::DATA_W), .DEPTH(DEPTH)) u_window (
		.clk   (clk),
		.we    (pop),
		.waddr (wr_q),
		.wdata (head.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Neighbour distances behind the current sample, centre first.
	always_comb begin
		unique case (st_q)
			4'd0:    nb_dist = job_q.plane_len;
			4'd1:    nb_dist = job_q.plane_len + hsj_pkg::DIST_W'(1);
			4'd2:    nb_dist = job_q.plane_len - hsj_pkg::DIST_W'(1);
			4'd3:    nb_dist = job_q.plane_len + hsj_pkg::DIST_W'(job_q.row_len);
			4'd4:    nb_dist = job_q.plane_len - hsj_pkg::DIST_W'(job_q.row_len);
			default: nb_dist = {job_q.plane_len[hsj_pkg::DIST_W-2:0], 1'b0};
		endcase
		sum = SUM_W'(base_q) + SUM_W'(DEPTH) - SUM_W'(nb_dist);
		if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
		raddr = sum[AW-1:0];
	end

	always_comb begin
		mul_a = (st_q == ST_SAMPLE) ? job_q.sample : rdata;
		unique case (st_q)
			4'd1:       mul_b = coef.center;
			4'd2, 4'd3: mul_b = coef.wx;
			4'd4, 4'd5: mul_b = coef.wy;
			default:    mul_b = coef.wz;
		endcase
	end

	assign rnd      = acc_q + hsj_pkg::ACC_W'(32768);
	assign nv_full  = rnd[hsj_pkg::ACC_W-1:16];
	assign diff     = {c_q[hsj_pkg::DATA_W-1], c_q} - {nv_q[hsj_pkg::DATA_W-1], nv_q};
	assign mag      = diff[hsj_pkg::DATA_W] ? hsj_pkg::DATA_W'(0) - diff : diff;
	assign res_sum  = {1'b0, res_q} + {1'b0, sq_q};
	assign load_out = busy_q && (st_q == ST_OUT) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (st_q == 4'd1) c_q <= rdata;
		if (st_q == ST_ROUND) begin
			if (nv_full > NV_MAX)
				nv_q <= 32'sh7fffffff;
			else if (nv_full < NV_MIN)
				nv_q <= 32'sh80000000;
			else
				nv_q <= nv_full[hsj_pkg::DATA_W-1:0];
		end
		if (st_q == ST_SQUARE)
			sq_q <= mag[hsj_pkg::DATA_W] ? '1 : mag[hsj_pkg::DATA_W-1:0] * mag[hsj_pkg::DATA_W-1:0];
		if (pop) job_q <= head;
		if (load_out) begin
			result_ch.new_value    <= nv_q;
			result_ch.residual_sum <= res_sum[hsj_pkg::RES_W] ? '1 : res_sum[hsj_pkg::RES_W-1:0];
			result_ch.last_point   <= job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			st_q        <= '0;
			wr_q        <= '0;
			base_q      <= '0;
			prod_v_s1   <= 1'b0;
			acc_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			prod_v_s1 <= busy_q && (st_q >= 4'd1) && (st_q <= ST_SAMPLE);
			if (pop) acc_q <= '0;
			else if (prod_v_s1) acc_q <= acc_q + hsj_pkg::ACC_W'(prod_s1);
			if (pop) begin
				base_q <= wr_q;
				wr_q   <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
				busy_q <= head.emit;
				st_q   <= '0;
				if (head.first) res_q <= '0;
			end else if (busy_q) begin
				if (st_q != ST_OUT) begin
					st_q <= st_q + 4'd1;
				end else if (load_out) begin
					busy_q <= 1'b0;
					res_q  <= res_sum[hsj_pkg::RES_W] ? '1 : res_sum[hsj_pkg::RES_W-1:0];
				end
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid = out_valid_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> st_q <= ST_OUT) else $error("step counter ran past the output step");
	a_res_grows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> res_q >= $past(res_q)) else $error("running residual decreased");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && st_q != ST_OUT) |=> !$past(pop) || st_q == 4'd0)
		else $error("item taken while a stencil was in progress");

endmodule
